// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file vop_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define VOP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define VOP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/vop_pkg.sv -----
// Shared widths, payload structs and the abs_val helper of the voltage-oriented Park transform.
// Depends on nothing.
package vop_pkg;

    localparam int IN_W   = 32;
    localparam int MAG_W  = 31;
    localparam int UNIT_W = 22;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int OUT_W  = 32;

    typedef struct packed {
        logic signed [IN_W-1:0] va;
        logic signed [IN_W-1:0] vb;
        logic signed [IN_W-1:0] ia;
        logic signed [IN_W-1:0] ib;
    } sample_t;

    typedef struct packed {
        logic signed [IN_W-1:0] ia;
        logic signed [IN_W-1:0] ib;
        logic [MAG_W-1:0]       vmag;
        logic [MAG_W-1:0]       imag;
        logic                   zero;
    } div_side_t;

    function automatic logic [IN_W-1:0] abs_val(input logic signed [IN_W-1:0] x);
        logic signed [IN_W-1:0] n;
        n = -x;
        return x[IN_W-1] ? $unsigned(n) : $unsigned(x);
    endfunction

endpackage

// ----- design/vop_square.sv -----
// Two-stage front end: absolute values squared, then summed per vector.
// Depends on vop_pkg.
module vop_square (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  vop_pkg::sample_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output vop_pkg::sample_t          out_data,
    output logic [vop_pkg::SQ_W-1:0]  volt_sq,
    output logic [vop_pkg::SQ_W-1:0]  curr_sq
);
    import vop_pkg::*;

    logic [1:0]       v_reg;
    logic [2:0]       rdy;
    sample_t          samp_reg [2];
    logic [SQ_W-1:0]  sq_reg [4];
    logic [SQ_W-1:0]  sq_next [4];
    logic [SQ_W-1:0]  vsum_reg;
    logic [SQ_W-1:0]  isum_reg;
    logic [SQ_W-1:0]  vsum_next;
    logic [SQ_W-1:0]  isum_next;
    logic [IN_W-1:0]  mag [4];

    always_comb
    begin
        rdy[2] = out_ready;
        rdy[1] = !v_reg[1] || rdy[2];
        rdy[0] = !v_reg[0] || rdy[1];
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        mag[0] = abs_val(in_data.va);
        mag[1] = abs_val(in_data.vb);
        mag[2] = abs_val(in_data.ia);
        mag[3] = abs_val(in_data.ib);
        for (int k = 0; k < 4; k++)
        begin
            sq_next[k] = SQ_W'(mag[k]) * SQ_W'(mag[k]);
        end
        vsum_next = sq_reg[0] + sq_reg[1];
        isum_next = sq_reg[2] + sq_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            samp_reg[0] <= in_data;
            sq_reg      <= sq_next;
        end
        if (rdy[1] && v_reg[0])
        begin
            samp_reg[1] <= samp_reg[0];
            vsum_reg    <= vsum_next;
            isum_reg    <= isum_next;
        end
    end

    assign out_valid = v_reg[1];
    assign out_data  = samp_reg[1];
    assign volt_sq   = vsum_reg;
    assign curr_sq   = isum_reg;

endmodule

// ----- design/vop_sqrt.sv -----
// Bit-per-stage integer square root, two lanes, sample carried alongside.
// Depends on vop_pkg.
module vop_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  vop_pkg::sample_t            in_data,
    input  logic [vop_pkg::SQ_W-1:0]    volt_sq,
    input  logic [vop_pkg::SQ_W-1:0]    curr_sq,
    output logic                        out_valid,
    input  logic                        out_ready,
    output vop_pkg::sample_t            out_data,
    output logic [vop_pkg::ROOT_W-1:0]  volt_len,
    output logic [vop_pkg::ROOT_W-1:0]  curr_len
);
    import vop_pkg::*;

    localparam int N = ROOT_W;

    logic [N-1:0]      v_reg;
    logic [N-1:0]      v_in;
    logic [N:0]        rdy;
    sample_t           samp_reg  [N];
    logic [SQ_W-1:0]   rem_reg   [N][2];
    logic [ROOT_W-1:0] root_reg  [N][2];
    logic [SQ_W-1:0]   rem_next  [N][2];
    logic [ROOT_W-1:0] root_next [N][2];
    sample_t           samp_next [N];
    logic [SQ_W-1:0]   rem_cur;
    logic [ROOT_W-1:0] root_cur;
    logic [SQ_W+1:0]   trial;

    always_comb
    begin
        rdy[N] = out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        rem_cur  = '0;
        root_cur = '0;
        trial    = '0;
        for (int i = 0; i < N; i++)
        begin
            v_in[i]      = (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
            samp_next[i] = (i == 0) ? in_data : samp_reg[(i == 0) ? 0 : i - 1];
            for (int l = 0; l < 2; l++)
            begin
                if (i == 0)
                begin
                    rem_cur  = (l == 0) ? volt_sq : curr_sq;
                    root_cur = '0;
                end
                else
                begin
                    rem_cur  = rem_reg[(i == 0) ? 0 : i - 1][l];
                    root_cur = root_reg[(i == 0) ? 0 : i - 1][l];
                end
                // try bit (N-1-i): (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
                trial = ((SQ_W+2)'(root_cur) << (N - i))
                      + ((SQ_W+2)'(1) << (2 * (N - 1 - i)));
                if ((SQ_W+2)'(rem_cur) >= trial)
                begin
                    rem_next[i][l]  = rem_cur - trial[SQ_W-1:0];
                    root_next[i][l] = root_cur | (ROOT_W'(1) << (N - 1 - i));
                end
                else
                begin
                    rem_next[i][l]  = rem_cur;
                    root_next[i][l] = root_cur;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_in[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (rdy[i] && v_in[i])
            begin
                samp_reg[i] <= samp_next[i];
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_data  = samp_reg[N-1];
    assign volt_len  = root_reg[N-1][0];
    assign curr_len  = root_reg[N-1][1];

endmodule

// ----- design/vop_div.sv -----
// Restoring divider, one quotient bit per stage, sine and cosine lanes.
// Depends on vop_pkg.
module vop_div #(
    parameter int FRAC_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [vop_pkg::ROOT_W-1:0]    den,
    input  logic [vop_pkg::IN_W-1:0]      num_sin,
    input  logic [vop_pkg::IN_W-1:0]      num_cos,
    input  logic                          neg_sin,
    input  logic                          neg_cos,
    input  vop_pkg::div_side_t            in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [FRAC_BITS+1:0]   sine,
    output logic signed [FRAC_BITS+1:0]   cosine,
    output vop_pkg::div_side_t            out_side
);
    import vop_pkg::*;

    localparam int N  = FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 2;
    localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

    logic [N-1:0]      v_reg;
    logic [N-1:0]      v_in;
    logic [N:0]        rdy;
    div_side_t         side_reg  [N];
    div_side_t         side_next [N];
    logic [ROOT_W-1:0] den_reg   [N];
    logic [ROOT_W-1:0] den_next  [N];
    logic [1:0]        neg_reg   [N];
    logic [1:0]        neg_next  [N];
    logic [IN_W-1:0]   rem_reg   [N][2];
    logic [IN_W-1:0]   rem_next  [N][2];
    logic [QW-1:0]     q_reg     [N][2];
    logic [QW-1:0]     q_next    [N][2];
    logic [IN_W-1:0]   rem_cur;
    logic [QW-1:0]     q_cur;
    logic [IN_W:0]     r;
    logic [QW-1:0]     qc [2];
    logic signed [SW-1:0] mag [2];
    logic signed [SW-1:0] res [2];
    logic [1:0]        neg_out;

    always_comb
    begin
        rdy[N] = out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        rem_cur = '0;
        q_cur   = '0;
        r       = '0;
        for (int i = 0; i < N; i++)
        begin
            v_in[i]      = (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
            side_next[i] = (i == 0) ? in_side : side_reg[(i == 0) ? 0 : i - 1];
            den_next[i]  = (i == 0) ? den : den_reg[(i == 0) ? 0 : i - 1];
            neg_next[i]  = (i == 0) ? {neg_cos, neg_sin} : neg_reg[(i == 0) ? 0 : i - 1];
            for (int l = 0; l < 2; l++)
            begin
                if (i == 0)
                begin
                    rem_cur = (l == 0) ? num_sin : num_cos;
                    q_cur   = '0;
                    r       = {1'b0, rem_cur};
                end
                else
                begin
                    rem_cur = rem_reg[(i == 0) ? 0 : i - 1][l];
                    q_cur   = q_reg[(i == 0) ? 0 : i - 1][l];
                    r       = {rem_cur, 1'b0};
                end
                if (r >= {1'b0, den_next[i]})
                begin
                    rem_next[i][l] = IN_W'(r - {1'b0, den_next[i]});
                    q_next[i][l]   = q_cur | (QW'(1) << (FRAC_BITS - i));
                end
                else
                begin
                    rem_next[i][l] = r[IN_W-1:0];
                    q_next[i][l]   = q_cur;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_in[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (rdy[i] && v_in[i])
            begin
                side_reg[i] <= side_next[i];
                den_reg[i]  <= den_next[i];
                neg_reg[i]  <= neg_next[i];
                rem_reg[i]  <= rem_next[i];
                q_reg[i]    <= q_next[i];
            end
        end
    end

    // clamp to one, apply sign, zero out when the voltage length is zero
    always_comb
    begin
        neg_out = neg_reg[N-1];
        for (int l = 0; l < 2; l++)
        begin
            qc[l]  = (q_reg[N-1][l] > ONE) ? ONE : q_reg[N-1][l];
            mag[l] = $signed({1'b0, qc[l]});
            if (side_reg[N-1].zero)
            begin
                res[l] = '0;
            end
            else if (neg_out[l])
            begin
                res[l] = -mag[l];
            end
            else
            begin
                res[l] = mag[l];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign sine      = res[0];
    assign cosine    = res[1];

endmodule

// ----- design/vop_rotate.sv -----
// Rotation of the current onto the voltage frame: product stage, then sum and saturate.
// Depends on vop_pkg.
module vop_rotate #(
    parameter int          FRAC_BITS = 20,
    parameter logic [31:0] SAT_MAX   = 32'h7FFF_FFFF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [FRAC_BITS+1:0]        sine,
    input  logic signed [FRAC_BITS+1:0]        cosine,
    input  vop_pkg::div_side_t                 in_side,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [vop_pkg::MAG_W-1:0]          volt_magnitude,
    output logic [vop_pkg::MAG_W-1:0]          curr_magnitude,
    output logic signed [vop_pkg::UNIT_W-1:0]  phase_sine,
    output logic signed [vop_pkg::UNIT_W-1:0]  phase_cosine,
    output logic signed [vop_pkg::OUT_W-1:0]   direct_part,
    output logic signed [vop_pkg::OUT_W-1:0]   quadrature_part,
    output logic                               zero_voltage
);
    import vop_pkg::*;

    localparam int SW = FRAC_BITS + 2;
    localparam int PW = IN_W + FRAC_BITS + 2;
    localparam logic signed [PW:0] HI = (PW+1)'(SAT_MAX);
    localparam logic signed [PW:0] LO = -HI - (PW+1)'(1);

    logic [1:0]              v_reg;
    logic [2:0]              rdy;
    logic signed [PW-1:0]    prod_reg  [4];
    logic signed [PW-1:0]    prod_next [4];
    logic signed [SW-1:0]    sin_reg   [2];
    logic signed [SW-1:0]    cos_reg   [2];
    div_side_t               side_reg  [2];
    logic signed [OUT_W-1:0] d_reg;
    logic signed [OUT_W-1:0] q_reg;
    logic signed [OUT_W-1:0] d_next;
    logic signed [OUT_W-1:0] q_next;
    logic signed [PW:0]      d_sum;
    logic signed [PW:0]      q_sum;

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [PW:0] x);
        logic signed [PW:0] y;
        y = (x > HI) ? HI : ((x < LO) ? LO : x);
        return y[OUT_W-1:0];
    endfunction

    always_comb
    begin
        rdy[2] = out_ready;
        rdy[1] = !v_reg[1] || rdy[2];
        rdy[0] = !v_reg[0] || rdy[1];
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        prod_next[0] = PW'(in_side.ia) * PW'(cosine);
        prod_next[1] = PW'(in_side.ib) * PW'(sine);
        prod_next[2] = PW'(in_side.ib) * PW'(cosine);
        prod_next[3] = PW'(in_side.ia) * PW'(sine);
        d_sum  = (PW+1)'(prod_reg[0] >>> FRAC_BITS) + (PW+1)'(prod_reg[1] >>> FRAC_BITS);
        q_sum  = (PW+1)'(prod_reg[2] >>> FRAC_BITS) - (PW+1)'(prod_reg[3] >>> FRAC_BITS);
        d_next = sat(d_sum);
        q_next = sat(q_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            prod_reg    <= prod_next;
            sin_reg[0]  <= sine;
            cos_reg[0]  <= cosine;
            side_reg[0] <= in_side;
        end
        if (rdy[1] && v_reg[0])
        begin
            d_reg       <= d_next;
            q_reg       <= q_next;
            sin_reg[1]  <= sin_reg[0];
            cos_reg[1]  <= cos_reg[0];
            side_reg[1] <= side_reg[0];
        end
    end

    assign out_valid       = v_reg[1];
    assign volt_magnitude  = side_reg[1].vmag;
    assign curr_magnitude  = side_reg[1].imag;
    assign phase_sine      = UNIT_W'(sin_reg[1]);
    assign phase_cosine    = UNIT_W'(cos_reg[1]);
    assign direct_part     = d_reg;
    assign quadrature_part = q_reg;
    assign zero_voltage    = side_reg[1].zero;

endmodule

// ----- design/voltage_oriented_park_transform.sv -----
// Channel   Handshake               Payload
// input     in_valid / in_ready     volt_alpha volt_beta curr_alpha curr_beta
// output    out_valid / out_ready   magnitudes, sine, cosine, d, q, zero flag
//
// One transfer per cycle in and out while out_ready stays high; the pipeline holds
// 2 square/sum stages, 32 square-root stages, FRAC_BITS + 1 divider stages, 2 rotate stages.
// Reset clears only the stage valid bits.
// A stage holds only while the stage after it is full and stalled, so bubbles close up.
// Top level of the voltage-oriented Park transform; depends on vop_pkg and the vop_* stages.
module voltage_oriented_park_transform #(
    parameter int FRAC_BITS = 20,
    parameter int WORD_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [vop_pkg::IN_W-1:0]    volt_alpha,
    input  logic signed [vop_pkg::IN_W-1:0]    volt_beta,
    input  logic signed [vop_pkg::IN_W-1:0]    curr_alpha,
    input  logic signed [vop_pkg::IN_W-1:0]    curr_beta,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [vop_pkg::MAG_W-1:0]          volt_magnitude,
    output logic [vop_pkg::MAG_W-1:0]          curr_magnitude,
    output logic signed [vop_pkg::UNIT_W-1:0]  phase_sine,
    output logic signed [vop_pkg::UNIT_W-1:0]  phase_cosine,
    output logic signed [vop_pkg::OUT_W-1:0]   direct_part,
    output logic signed [vop_pkg::OUT_W-1:0]   quadrature_part,
    output logic                               zero_voltage
);
    import vop_pkg::*;

    localparam logic [31:0] SAT_MAX = (WORD_BITS >= 32) ? 32'h7FFF_FFFF
                                    : 32'((64'd1 << (WORD_BITS - 1)) - 64'd1);

    sample_t              in_data;
    sample_t              sq_data;
    sample_t              rt_data;
    logic                 sq_valid;
    logic                 sq_ready;
    logic [SQ_W-1:0]      volt_sq;
    logic [SQ_W-1:0]      curr_sq;
    logic                 rt_valid;
    logic                 rt_ready;
    logic [ROOT_W-1:0]    volt_len;
    logic [ROOT_W-1:0]    curr_len;
    div_side_t            div_side;
    div_side_t            rot_side;
    logic                 dv_valid;
    logic                 dv_ready;
    logic signed [FRAC_BITS+1:0] sine;
    logic signed [FRAC_BITS+1:0] cosine;

    assign in_data.va = volt_alpha;
    assign in_data.vb = volt_beta;
    assign in_data.ia = curr_alpha;
    assign in_data.ib = curr_beta;

    vop_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_data  (sq_data),
        .volt_sq   (volt_sq),
        .curr_sq   (curr_sq)
    );

    vop_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_data   (sq_data),
        .volt_sq   (volt_sq),
        .curr_sq   (curr_sq),
        .out_valid (rt_valid),
        .out_ready (rt_ready),
        .out_data  (rt_data),
        .volt_len  (volt_len),
        .curr_len  (curr_len)
    );

    always_comb
    begin
        div_side.ia   = rt_data.ia;
        div_side.ib   = rt_data.ib;
        div_side.vmag = (volt_len > SAT_MAX) ? MAG_W'(SAT_MAX) : MAG_W'(volt_len);
        div_side.imag = (curr_len > SAT_MAX) ? MAG_W'(SAT_MAX) : MAG_W'(curr_len);
        div_side.zero = (volt_len == '0);
    end

    vop_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .in_ready  (rt_ready),
        .den       (volt_len),
        .num_sin   (abs_val(rt_data.vb)),
        .num_cos   (abs_val(rt_data.va)),
        .neg_sin   (rt_data.vb[IN_W-1]),
        .neg_cos   (rt_data.va[IN_W-1]),
        .in_side   (div_side),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .sine      (sine),
        .cosine    (cosine),
        .out_side  (rot_side)
    );

    vop_rotate #(
        .FRAC_BITS (FRAC_BITS),
        .SAT_MAX   (SAT_MAX)
    ) u_rotate (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (dv_valid),
        .in_ready        (dv_ready),
        .sine            (sine),
        .cosine          (cosine),
        .in_side         (rot_side),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .volt_magnitude  (volt_magnitude),
        .curr_magnitude  (curr_magnitude),
        .phase_sine      (phase_sine),
        .phase_cosine    (phase_cosine),
        .direct_part     (direct_part),
        .quadrature_part (quadrature_part),
        .zero_voltage    (zero_voltage)
    );

endmodule

// ----- design/vop_checker.sv -----
// Port-level checker for the voltage-oriented Park transform, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module vop_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [31:0] volt_alpha,
    input logic signed [31:0] volt_beta,
    input logic signed [31:0] curr_alpha,
    input logic signed [31:0] curr_beta,
    input logic               out_valid,
    input logic               out_ready,
    input logic [30:0]        volt_magnitude,
    input logic [30:0]        curr_magnitude,
    input logic signed [21:0] phase_sine,
    input logic signed [21:0] phase_cosine,
    input logic signed [31:0] direct_part,
    input logic signed [31:0] quadrature_part,
    input logic               zero_voltage
);

    // hold an offered transfer until accepted
    `VOP_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
        in_valid && $stable(volt_alpha) && $stable(volt_beta) && $stable(curr_alpha)
        && $stable(curr_beta))

    // hold a stalled result
    `VOP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(volt_magnitude) && $stable(curr_magnitude)
        && $stable(phase_sine) && $stable(phase_cosine) && $stable(direct_part)
        && $stable(quadrature_part) && $stable(zero_voltage))

    // zero voltage drops the angle and the rotated current
    `VOP_ASSERT_IMP(a_zero_clears, clk, rst_n, out_valid && zero_voltage,
        phase_sine == 0 && phase_cosine == 0 && direct_part == 0 && quadrature_part == 0)

    // zero flag only with a zero voltage length
    `VOP_ASSERT_IMP(a_zero_mag, clk, rst_n, out_valid && zero_voltage, volt_magnitude == 0)

    // nonzero length never raises the flag
    `VOP_ASSERT_IMP(a_mag_flag, clk, rst_n, out_valid && volt_magnitude != 0, !zero_voltage)

endmodule

bind voltage_oriented_park_transform vop_checker u_vop_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for voltage_oriented_park_transform: directed table, then random samples.
// Expects magnitudes, sine/cosine, d/q from table or park_predict; checks in order; uses vop_pkg.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [vop_pkg::MAG_W-1:0]         vmag;
        logic [vop_pkg::MAG_W-1:0]         imag;
        logic signed [vop_pkg::UNIT_W-1:0] sn;
        logic signed [vop_pkg::UNIT_W-1:0] cs;
        logic signed [vop_pkg::OUT_W-1:0]  d;
        logic signed [vop_pkg::OUT_W-1:0]  q;
        logic                              zero;
    } dq_result_t;

    typedef struct {
        int          va, vb, ia, ib;
        bit          known;
        int unsigned vmag, imag;
        int          sn, cs, d, q;
        bit          zero;
    } vector_row_t;

    localparam int FRAC = 20;
    localparam longint WMAX = 64'sd2147483647;
    localparam int N_RANDOM = 440;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] volt_alpha = '0, volt_beta = '0, curr_alpha = '0, curr_beta = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [30:0] volt_magnitude, curr_magnitude;
    logic signed [21:0] phase_sine, phase_cosine;
    logic signed [31:0] direct_part, quadrature_part;
    logic zero_voltage;

    dq_result_t pending_dq[$];
    int fails = 0;
    int got = 0;
    int cycles = 0;
    int hold = 0;
    bit held = 1'b0;
    bit calm = 1'b0;

    voltage_oriented_park_transform u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .volt_alpha(volt_alpha), .volt_beta(volt_beta),
        .curr_alpha(curr_alpha), .curr_beta(curr_beta),
        .out_valid(out_valid), .out_ready(out_ready),
        .volt_magnitude(volt_magnitude), .curr_magnitude(curr_magnitude),
        .phase_sine(phase_sine), .phase_cosine(phase_cosine),
        .direct_part(direct_part), .quadrature_part(quadrature_part),
        .zero_voltage(zero_voltage)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned mag64(int a, int b);
        longint unsigned ua, ub;
        ua = (a < 0) ? longint'(-longint'(a)) : longint'(a);
        ub = (b < 0) ? longint'(-longint'(b)) : longint'(b);
        return root64(ua * ua + ub * ub);
    endfunction

    function automatic longint unit_ratio(int num, longint unsigned len);
        longint unsigned n, qt;
        n = (num < 0) ? longint'(-longint'(num)) : longint'(num);
        qt = (n << FRAC) / len;
        if (qt > (64'd1 << FRAC))
            qt = 64'd1 << FRAC;
        return (num < 0) ? -longint'(qt) : longint'(qt);
    endfunction

    function automatic longint clamp_word(longint v);
        if (v > WMAX)
            return WMAX;
        if (v < -WMAX - 1)
            return -WMAX - 1;
        return v;
    endfunction

    function automatic dq_result_t park_predict(int va, int vb, int ia, int ib);
        dq_result_t r;
        longint unsigned vlen, ilen;
        longint sn, cs;
        vlen = mag64(va, vb);
        ilen = mag64(ia, ib);
        r.vmag = (vlen > WMAX) ? 31'h7fffffff : vlen[30:0];
        r.imag = (ilen > WMAX) ? 31'h7fffffff : ilen[30:0];
        r.zero = (vlen == 0);
        r.sn = '0;
        r.cs = '0;
        r.d = '0;
        r.q = '0;
        if (!r.zero)
        begin
            sn = unit_ratio(vb, vlen);
            cs = unit_ratio(va, vlen);
            r.sn = sn[21:0];
            r.cs = cs[21:0];
            r.d = 32'(clamp_word(((longint'(ia) * cs) >>> FRAC)
                               + ((longint'(ib) * sn) >>> FRAC)));
            r.q = 32'(clamp_word(((longint'(ib) * cs) >>> FRAC)
                               - ((longint'(ia) * sn) >>> FRAC)));
        end
        return r;
    endfunction

    function automatic int pick_word();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return int'($urandom_range(0, 1 << 24)) - (1 << 23);
            3: return 0;
            4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 35);
    endfunction

    task automatic send_sample(int va, int vb, int ia, int ib, dq_result_t exp_r);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        volt_alpha <= va;
        volt_beta <= vb;
        curr_alpha <= ia;
        curr_beta <= ib;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_dq.push_back(exp_r);
    endtask

    vector_row_t vectors[] = '{
        '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1},
        '{0, 0, 3145728, 4194304, 1, 0, 5242880, 0, 0, 0, 0, 1},
        '{1048576, 0, 2097152, 0, 1, 1048576, 2097152, 0, 1048576, 2097152, 0, 0},
        '{0, 1048576, 2097152, 0, 1, 1048576, 2097152, 1048576, 0, 0, -2097152, 0},
        '{-1048576, 0, 1048576, 0, 1, 1048576, 1048576, 0, -1048576, -1048576, 0, 0},
        '{1, 0, 32'h80000000, 32'h80000000, 1, 1, 32'h7fffffff, 0, 1048576,
          32'h80000000, 32'h80000000, 0},
        '{32'h80000000, 0, 32'h80000000, 0, 1, 32'h7fffffff, 32'h7fffffff, 0, -1048576,
          32'h7fffffff, 0, 0},
        '{32'h80000000, 32'h80000000, 123456789, -987654321, 0, 0, 0, 0, 0, 0, 0, 0},
        '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0, 0},
        '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, -1, 5, -7, 0, 0, 0, 0, 0, 0, 0, 0},
        '{3, 4, -3, 4, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-3145728, 4194304, 1048576, 1048576, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, -1, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    initial
    begin
        dq_result_t r;
        int va, vb, ia, ib;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (vectors[i])
        begin
            if (vectors[i].known)
            begin
                r.vmag = vectors[i].vmag[30:0];
                r.imag = vectors[i].imag[30:0];
                r.sn = vectors[i].sn[21:0];
                r.cs = vectors[i].cs[21:0];
                r.d = vectors[i].d;
                r.q = vectors[i].q;
                r.zero = vectors[i].zero;
            end
            else
                r = park_predict(vectors[i].va, vectors[i].vb, vectors[i].ia, vectors[i].ib);
            send_sample(vectors[i].va, vectors[i].vb, vectors[i].ia, vectors[i].ib, r);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            calm = (n >= 200 && n < 300);
            va = pick_word();
            vb = pick_word();
            ia = pick_word();
            ib = pick_word();
            send_sample(va, vb, ia, ib, park_predict(va, vb, ia, ib));
        end
        calm = 1'b0;
        in_valid <= 1'b0;
        while (pending_dq.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("voltage_oriented_park_transform: match");
        else
            $display("voltage_oriented_park_transform: mismatch");
        $finish;
    end

    // hold off once for a long stretch so the pipeline fills and stalls the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold > 0)
        begin
            hold <= hold - 1;
            out_ready <= 1'b0;
        end
        else if (!held && got >= 60)
        begin
            held <= 1'b1;
            hold <= 400;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge clk)
    begin
        dq_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            got++;
            if (pending_dq.size() == 0)
            begin
                $error("unexpected transfer on output");
                fails++;
            end
            else
            begin
                e = pending_dq.pop_front();
                if (volt_magnitude !== e.vmag)
                begin
                    $error("volt_magnitude exp %0d got %0d", e.vmag, volt_magnitude);
                    fails++;
                end
                if (curr_magnitude !== e.imag)
                begin
                    $error("curr_magnitude exp %0d got %0d", e.imag, curr_magnitude);
                    fails++;
                end
                if (phase_sine !== e.sn)
                begin
                    $error("phase_sine exp %0d got %0d", e.sn, phase_sine);
                    fails++;
                end
                if (phase_cosine !== e.cs)
                begin
                    $error("phase_cosine exp %0d got %0d", e.cs, phase_cosine);
                    fails++;
                end
                if (direct_part !== e.d)
                begin
                    $error("direct_part exp %0d got %0d", e.d, direct_part);
                    fails++;
                end
                if (quadrature_part !== e.q)
                begin
                    $error("quadrature_part exp %0d got %0d", e.q, quadrature_part);
                    fails++;
                end
                if (zero_voltage !== e.zero)
                begin
                    $error("zero_voltage exp %0d got %0d", e.zero, zero_voltage);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("voltage_oriented_park_transform: mismatch");
            $finish;
        end
    end

endmodule

// ----- voltage_oriented_park_transform.f -----
+incdir+design
design/vop_pkg.sv
design/vop_square.sv
design/vop_sqrt.sv
design/vop_div.sv
design/vop_rotate.sv
design/voltage_oriented_park_transform.sv
design/vop_checker.sv
tb/tb_top.sv
